// ----- rtl/mcd_pkg.sv -----
// Shared types, character codes and the letter lookup for the Morse code decoder.
// No dependencies; every module of the decoder imports this package.
`timescale 1ns / 1ps

package mcd_pkg;

	// ASCII codes that the decoder recognizes or produces.
	localparam logic [7:0] DOT_CHAR   = 8'd46;
	localparam logic [7:0] DASH_CHAR  = 8'd45;
	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [7:0] SLASH_CHAR = 8'd47;

	// Token length bookkeeping: up to four symbols, five marks an overlong token.
	localparam logic [2:0] MAX_LEN      = 3'd4;
	localparam logic [2:0] OVERLONG_LEN = 3'd5;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// One classified request: an optional letter and an optional word space.
	typedef struct packed {
		logic       has_letter;
		logic [7:0] letter;
		logic       word;
	} mcd_entry_t;

	// Write side of the queue.
	typedef struct packed {
		logic       valid;
		mcd_entry_t entry;
	} mcd_push_t;

	// Status of the queue as seen by both sides.
	typedef struct packed {
		logic       not_empty;
		logic       full;
		mcd_entry_t head;
	} mcd_qstat_t;

	// Letter for index (1 << length) | code; zero means no letter.
	function automatic logic [7:0] letter_of(input logic [4:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd2:  ch = "E";
			5'd3:  ch = "T";
			5'd4:  ch = "I";
			5'd5:  ch = "A";
			5'd6:  ch = "N";
			5'd7:  ch = "M";
			5'd8:  ch = "S";
			5'd9:  ch = "U";
			5'd10: ch = "R";
			5'd11: ch = "W";
			5'd12: ch = "D";
			5'd13: ch = "K";
			5'd14: ch = "G";
			5'd15: ch = "O";
			5'd16: ch = "H";
			5'd17: ch = "V";
			5'd18: ch = "F";
			5'd20: ch = "L";
			5'd22: ch = "P";
			5'd23: ch = "J";
			5'd24: ch = "B";
			5'd25: ch = "X";
			5'd26: ch = "C";
			5'd27: ch = "Y";
			5'd28: ch = "Z";
			5'd29: ch = "Q";
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/mcd_front.sv -----
// Front part of the Morse code decoder: accepts characters, keeps the token state
// and classifies each character into a queue request. Depends on mcd_pkg.
`timescale 1ns / 1ps

module mcd_front
	import mcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_char,
	input  logic       end_of_message,
	input  logic       queue_full,
	output logic       in_ready,
	output mcd_push_t  push
);

	logic [3:0] code_bits_q;
	logic [2:0] code_length_q;
	logic       token_invalid_q;

	logic       accept;
	logic       is_sym;
	logic [3:0] nbits;
	logic [2:0] nlen;
	logic       ninv;
	logic       ends;
	logic       word;
	logic [4:0] idx;
	logic [7:0] letter;
	logic       has_letter;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Next token state and whether this character ends the token.
	always_comb begin
		is_sym = (in_char == DOT_CHAR) || (in_char == DASH_CHAR);
		nbits  = code_bits_q;
		nlen   = code_length_q;
		ninv   = token_invalid_q;
		ends   = end_of_message;
		word   = end_of_message;
		if (is_sym) begin
			if (code_length_q < MAX_LEN) begin
				nbits = {code_bits_q[2:0], in_char == DASH_CHAR};
				nlen  = code_length_q + 3'd1;
			end else begin
				nlen = OVERLONG_LEN;
			end
		end else if (in_char == SPACE_CHAR) begin
			ends = 1'b1;
		end else if (in_char == SLASH_CHAR) begin
			ends = 1'b1;
			word = 1'b1;
		end else begin
			ninv = 1'b1;
		end
	end

	// Letter lookup on the finished token.
	always_comb begin
		idx        = 5'(5'd1 << nlen) | {1'b0, nbits};
		letter     = letter_of(idx);
		has_letter = ends && !ninv && (nlen >= 3'd1) && (nlen <= MAX_LEN) && (letter != 8'd0);
	end

	always_comb begin
		push.valid            = accept && (has_letter || word);
		push.entry.has_letter = has_letter;
		push.entry.letter     = letter;
		push.entry.word       = word;
	end

	// Token state: cleared when a token ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q     <= 4'd0;
			code_length_q   <= 3'd0;
			token_invalid_q <= 1'b0;
		end else if (accept) begin
			if (ends) begin
				code_bits_q     <= 4'd0;
				code_length_q   <= 3'd0;
				token_invalid_q <= 1'b0;
			end else begin
				code_bits_q     <= nbits;
				code_length_q   <= nlen;
				token_invalid_q <= ninv;
			end
		end
	end

endmodule

// ----- rtl/mcd_queue.sv -----
// Short queue of classified requests between the front and back parts.
// Depends on mcd_pkg for the entry type and the depth.
`timescale 1ns / 1ps

module mcd_queue
	import mcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mcd_push_t  push,
	input  logic       pop,
	output mcd_qstat_t stat
);

	mcd_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == QCNT_W'(QDEPTH));
	assign stat.head      = mem_q[rd_ptr_q];

	assign do_push = push.valid && !stat.full;
	assign do_pop  = pop && stat.not_empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/mcd_back.sv -----
// Back part of the Morse code decoder: turns queued requests into output
// characters through an output register. Depends on mcd_pkg.
`timescale 1ns / 1ps

module mcd_back
	import mcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mcd_qstat_t stat,
	output logic       pop,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;
	logic       space_pending_q;

	logic load;
	logic emit_letter;

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

	// A request with a letter and a word space takes two output slots.
	assign load        = !out_valid_q || out_ready;
	assign emit_letter = stat.head.has_letter && !space_pending_q;
	assign pop         = load && stat.not_empty && !(emit_letter && stat.head.word);

	// Output register and the pending-space flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			space_pending_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= stat.not_empty;
			if (stat.not_empty) begin
				space_pending_q <= emit_letter && stat.head.word;
			end
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load && stat.not_empty) begin
			if (emit_letter) begin
				out_char_q <= stat.head.letter;
				last_q     <= !stat.head.word;
			end else begin
				out_char_q <= SPACE_CHAR;
				last_q     <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/morse_code_decoder.sv -----
// Morse code decoder, one character accepted per cycle while the queue has room.
// Throughput: one character per cycle while the 4-deep queue has room; a character that
// yields a letter and a word space takes two output slots, so a steady
// run of those, or a stalled output, fills the queue and drops s_tready.
// Reset: arst_n clears the token state, the queue and the output valid at once.
`timescale 1ns / 1ps

module morse_code_decoder
	import mcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_char
	input  logic       s_tlast,  // end_of_message
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_char
	output logic       m_tlast   // last_of_run
);

	mcd_push_t  push;
	mcd_qstat_t stat;
	logic       pop;

	mcd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_char        (s_tdata),
		.end_of_message (s_tlast),
		.queue_full     (stat.full),
		.in_ready       (s_tready),
		.push           (push)
	);

	mcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (stat)
	);

	mcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.pop         (pop),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_char    (m_tdata),
		.last_of_run (m_tlast)
	);

endmodule

// ----- rtl/mcd_checker.sv -----
// Port-level checks for the Morse code decoder, bound to the top level.
// Depends on mcd_pkg for character codes.
`timescale 1ns / 1ps

module mcd_checker
	import mcd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// Only upper-case letters and the word space are ever produced.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == SPACE_CHAR) || ((m_tdata >= 8'd65) && (m_tdata <= 8'd90)))
		else $error("output character out of range");

	// A word space is always the last result of its character.
	a_space_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == SPACE_CHAR) |-> m_tlast)
		else $error("word space without last mark");

	// A letter that is not last is followed at once by its word space.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tdata == SPACE_CHAR))
		else $error("letter not followed by word space");

endmodule

bind morse_code_decoder mcd_checker u_mcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for morse_code_decoder: streams Morse text in and checks every decoded char.
// Keeps its own model of the token state. Depends on mcd_pkg and rtl/morse_code_decoder.sv.
`timescale 1ns / 1ps

module tb_top;
	import mcd_pkg::*;

	// Letters of the Morse tree, indexed by (1 << length) | code; a blank means no letter.
	localparam logic [8*32-1:0] MORSE_TREE = "  ETIANMSURWDKGOHVF L PJBXCYZQ  ";
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 6;

	// How a generated token is terminated.
	typedef enum int {
		SEP_SPACE,
		SEP_SLASH,
		SEP_EOM_SYMBOL,
		SEP_EOM_SPACE,
		SEP_EOM_SLASH
	} token_end_e;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} decoded_char_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;  // [7:0] in_char
	logic       s_tlast  = 1'b0;  // end_of_message
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] out_char
	logic       m_tlast;          // last_of_run

	// Model of the token being assembled.
	logic [3:0] tok_bits = 4'd0;
	logic [2:0] tok_len  = 3'd0;
	logic       tok_bad  = 1'b0;

	decoded_char_t pending_out[$];
	decoded_char_t got_char;
	int errors     = 0;
	int items_sent = 0;

	// Idling knobs: zero switches the gaps or stalls off.
	int gap_max    = 0;
	int burst_left = 0;
	int stall_max  = 0;
	int run_left   = 0;
	bit rx_ready   = 1'b1;
	bit hold_req   = 1'b0;
	int hold_left  = 0;

	morse_code_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// Predicts the chars that one accepted request yields and queues them.
	task automatic decode_char(input logic [7:0] c, input logic eom);
		logic       ends;
		logic       word;
		logic [4:0] idx;
		logic [7:0] letter;
		ends   = 1'b0;
		word   = eom;
		letter = 8'd0;
		if (c == DOT_CHAR || c == DASH_CHAR) begin
			if (tok_len < MAX_LEN) begin
				tok_bits = {tok_bits[2:0], c == DASH_CHAR};
				tok_len  = tok_len + 3'd1;
			end else begin
				tok_len = OVERLONG_LEN;
			end
			ends = eom;
		end else if (c == SPACE_CHAR) begin
			ends = 1'b1;
		end else if (c == SLASH_CHAR) begin
			ends = 1'b1;
			word = 1'b1;
		end else begin
			tok_bad = 1'b1;
			ends    = eom;
		end
		if (ends) begin
			if (!tok_bad && tok_len != 3'd0 && tok_len <= MAX_LEN) begin
				idx    = (5'd1 << tok_len) | {1'b0, tok_bits};
				letter = MORSE_TREE[8*(31 - idx) +: 8];
				if (letter == SPACE_CHAR)
					letter = 8'd0;
			end
			tok_bits = 4'd0;
			tok_len  = 3'd0;
			tok_bad  = 1'b0;
		end
		if (letter != 8'd0)
			pending_out.push_back('{ch: letter, last: !word});
		if (word)
			pending_out.push_back('{ch: SPACE_CHAR, last: 1'b1});
	endtask

	// Offers one request, with a random gap between bursts, and waits for its handshake.
	task automatic send_item(input logic [7:0] c, input logic eom);
		int gap;
		if (gap_max > 0 && burst_left == 0) begin
			gap = $urandom_range(gap_max, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(24, 1);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eom;
		do @(posedge clk); while (!s_tready);
		decode_char(c, eom);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Sends a text string; the final char carries the end-of-message flag when asked.
	task automatic send_text(input string s, input bit eom_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], eom_last && i == s.len() - 1);
	endtask

	// Sends a token of random dots and dashes and terminates it as requested.
	task automatic send_token(input int nsym, input token_end_e how);
		logic [7:0] sym;
		for (int i = 0; i < nsym; i++) begin
			sym = $urandom_range(1) ? DASH_CHAR : DOT_CHAR;
			send_item(sym, how == SEP_EOM_SYMBOL && i == nsym - 1);
		end
		case (how)
			SEP_SPACE:      send_item(SPACE_CHAR, 1'b0);
			SEP_SLASH:      send_item(SLASH_CHAR, 1'b0);
			SEP_EOM_SYMBOL: if (nsym == 0) send_item(SPACE_CHAR, 1'b1);
			SEP_EOM_SPACE:  send_item(SPACE_CHAR, 1'b1);
			default:        send_item(SLASH_CHAR, 1'b1);
		endcase
	endtask

	// Mostly well-formed tokens, with stray bytes and tokens broken by a foreign byte.
	task automatic send_random_text(input int n_items);
		int         stop;
		int         pick;
		int         nsym;
		int         bad_at;
		token_end_e how;
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				pick = $urandom_range(99);
				if (pick < 8)
					nsym = 0;
				else if (pick < 18)
					nsym = $urandom_range(6, 5);
				else
					nsym = $urandom_range(4, 1);
				how = $urandom_range(1) ? SEP_SPACE : token_end_e'($urandom_range(4));
				send_token(nsym, how);
			end else if (pick < 88) begin
				send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
			end else begin
				nsym   = $urandom_range(3, 1);
				bad_at = $urandom_range(nsym - 1);
				for (int i = 0; i < nsym; i++) begin
					if (i == bad_at)
						send_item(8'($urandom_range(255)), 1'b0);
					send_item($urandom_range(1) ? DASH_CHAR : DOT_CHAR, 1'b0);
				end
				send_item(SPACE_CHAR, 1'b0);
			end
		end
	endtask

	// Stops offering requests until every predicted char has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Edge cases: empty, known, unknown and overlong tokens, foreign bytes, end of message.
	task automatic test_directed();
		gap_max   = 0;
		stall_max = 0;
		send_text(" ", 1'b0);
		send_text(".- ", 1'b0);
		send_text("--.. ", 1'b0);
		send_text("..-- ", 1'b0);
		send_text("..... ", 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(SLASH_CHAR, 1'b0);
		send_item(DASH_CHAR, 1'b1);
		send_item(SLASH_CHAR, 1'b1);
		drain();
	endtask

	// Back-to-back requests with the output always ready.
	task automatic test_full_rate();
		gap_max   = 0;
		stall_max = 0;
		send_random_text(300);
	endtask

	// Moderate gaps on the input and stalls on the output.
	task automatic test_mixed_idle();
		gap_max   = 6;
		stall_max = 5;
		send_random_text(500);
	endtask

	// The output holds off while words keep arriving, so the queue fills and stalls the input.
	task automatic test_backpressure();
		gap_max   = 0;
		stall_max = 0;
		s_tvalid <= 1'b0;
		hold_req  = 1'b1;
		@(posedge clk);
		wait (hold_left > 0);
		for (int i = 0; i < 20; i++) begin
			send_item(DASH_CHAR, 1'b0);
			send_item(SLASH_CHAR, 1'b0);
		end
		drain();
	endtask

	// Long output stalls with short input gaps.
	task automatic test_heavy_stall();
		gap_max   = 3;
		stall_max = 20;
		send_random_text(250);
	endtask

	// Long input gaps with the output always ready.
	task automatic test_sparse_input();
		gap_max   = 15;
		stall_max = 0;
		send_random_text(250);
	endtask

	// Output ready: run-length pattern of ready and stall, or a long counted hold-off.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_max == 0) begin
			m_tready <= 1'b1;
		end else begin
			if (run_left == 0) begin
				rx_ready = !rx_ready;
				run_left = rx_ready ? $urandom_range(12, 1) : $urandom_range(stall_max, 1);
			end
			run_left--;
			m_tready <= rx_ready;
		end
	end

	// Compares every accepted output char with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out.size() == 0) begin
				errors++;
				$display("%0t: unexpected char: expected none, actual out_char %h last_of_run %b",
					$time, m_tdata, m_tlast);
			end else begin
				got_char = pending_out.pop_front();
				if (m_tdata !== got_char.ch) begin
					errors++;
					$display("%0t: out_char mismatch: expected %h, actual %h",
						$time, got_char.ch, m_tdata);
				end
				if (m_tlast !== got_char.last) begin
					errors++;
					$display("%0t: last_of_run mismatch: expected %b, actual %b",
						$time, got_char.last, m_tlast);
				end
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rate();
		test_mixed_idle();
		test_backpressure();
		test_heavy_stall();
		test_sparse_input();
		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#8ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mcd_pkg.sv
rtl/mcd_front.sv
rtl/mcd_queue.sv
rtl/mcd_back.sv
rtl/morse_code_decoder.sv
rtl/mcd_checker.sv
bench/tb_top.sv
